[hw/rtl/cgi_pkg.sv]
// Shared types, codes and constants for the colour gradient interpolator.
package cgi_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int TIME_W  = 16;
    localparam int CHAN_W  = 16;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int INV_W   = 23;
    localparam int FRAC_W  = 17;
    localparam int DIV_STEPS = 23;
    localparam logic [15:0] MIN_SPACING_RST = 16'd655;
    localparam logic [CHAN_W-1:0] CHAN_ONE = 16'd4096;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DROP  = 3'd1;
    localparam logic [2:0] ST_ORDER = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_ZERO = 3'd1;
    localparam logic [2:0] IDX_ONE  = 3'd2;
    localparam logic [2:0] IDX_LAST = 3'd3;
    localparam logic [2:0] IDX_INC  = 3'd4;
    localparam logic [2:0] IDX_DEC  = 3'd5;

    localparam logic [1:0] COL_HOLD = 2'd0;
    localparam logic [1:0] COL_ZERO = 2'd1;
    localparam logic [1:0] COL_ONE  = 2'd2;
    localparam logic [1:0] COL_RD   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] time_req;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [6:0]  point_total;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic [2:0] idx_op;
        logic       cnt_clear;
        logic       append_wr;
        logic       div_start;
        logic       div_step;
        logic       cb_cap;
        logic       mul_cap;
        logic       frac_cap;
        logic       lerp_step;
        logic [1:0] col_op;
        logic       status_set;
        logic [2:0] status_val;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       cnt_full;
        logic       t_le;
        logic       t_ge;
        logic       gap_le_min;
        logic       idx_lt_last;
        logic       div_done;
        logic       lerp_done;
    } dp_sts_t;

endpackage

[hw/rtl/cgi_datapath.sv]
// Datapath: key point memories, search index, divider, fraction and lerp unit.
module cgi_datapath #(
    parameter int MAX_POINTS = cgi_pkg::DEF_MAX_POINTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cgi_pkg::in_item_t  in_item,
    input  logic [15:0]        min_spacing,
    input  cgi_pkg::dp_cmd_t   cmd,
    output cgi_pkg::dp_sts_t   sts,
    output cgi_pkg::out_item_t result
);
    import cgi_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [TIME_W-1:0]  key_time  [MAX_POINTS];
    logic [COLOR_W-1:0] key_color [MAX_POINTS];
    logic [INV_W-1:0]   key_inv   [MAX_POINTS];

    in_item_t           in_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [TIME_W-1:0]  rd_time_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic [INV_W-1:0]   rd_inv_reg;
    logic [COLOR_W-1:0] ca_reg, cb_reg;
    logic [38:0]        prod_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [1:0]         ch_reg;
    logic [CHAN_W-1:0]  col_reg [3];
    logic [2:0]         status_reg;
    logic [15:0]        divisor_reg;
    logic [15:0]        rem_reg;
    logic [INV_W-1:0]   quo_reg;
    logic [4:0]         div_cnt_reg;

    logic [CW-1:0]      cnt_m1;
    logic [COLOR_W-1:0] in_color;
    logic [TIME_W-1:0]  gap;
    logic [16:0]        trial;
    logic               qbit;
    logic [CHAN_W-1:0]  ch_a, ch_b, ch_diff, lerp_val;
    logic               ch_up;
    logic [32:0]        lerp_prod;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign in_color = {in_reg.blue_in, in_reg.green_in, in_reg.red_in};
    assign gap      = in_reg.time_req - rd_time_reg;

    // restoring divider for 2^22 / gap, one quotient bit per step
    assign trial = {rem_reg, (div_cnt_reg == 5'(DIV_STEPS))};
    assign qbit  = (trial >= {1'b0, divisor_reg});

    always_comb begin
        ch_a      = ca_reg[ch_reg*CHAN_W +: CHAN_W];
        ch_b      = cb_reg[ch_reg*CHAN_W +: CHAN_W];
        ch_up     = (ch_b >= ch_a);
        ch_diff   = ch_up ? (ch_b - ch_a) : (ch_a - ch_b);
        lerp_prod = ch_diff * frac_reg;
        lerp_val  = ch_up ? (ch_a + lerp_prod[31:16]) : (ch_a - lerp_prod[31:16]);
    end

    always_comb begin
        unique case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_ONE:  idx_next = AW'(1);
            IDX_LAST: idx_next = cnt_m1[AW-1:0];
            IDX_INC:  idx_next = idx_reg + AW'(1);
            IDX_DEC:  idx_next = idx_reg - AW'(1);
            default:  idx_next = idx_reg;
        endcase
        cnt_next = cnt_reg;
        if (cmd.cnt_clear) begin
            cnt_next = '0;
        end else if (cmd.append_wr) begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        rd_time_reg  <= key_time[idx_reg];
        rd_color_reg <= key_color[idx_reg];
        rd_inv_reg   <= key_inv[idx_reg];
        if (cmd.append_wr) begin
            key_time[cnt_reg[AW-1:0]]  <= in_reg.time_req;
            key_color[cnt_reg[AW-1:0]] <= in_color;
            if (cnt_reg != '0) begin
                key_inv[cnt_m1[AW-1:0]] <= quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_in) begin
            in_reg <= in_item;
        end
        if (cmd.cb_cap) begin
            cb_reg <= rd_color_reg;
        end
        if (cmd.mul_cap) begin
            ca_reg   <= rd_color_reg;
            prod_reg <= (in_reg.time_req - rd_time_reg) * rd_inv_reg;
        end
        if (cmd.frac_cap) begin
            frac_reg <= (prod_reg[38:6] > 33'(FRAC_ONE)) ? FRAC_ONE : prod_reg[22:6];
            ch_reg   <= '0;
        end
        if (cmd.lerp_step) begin
            col_reg[ch_reg] <= lerp_val;
            ch_reg          <= ch_reg + 2'd1;
        end
        case (cmd.col_op)
            COL_ZERO: begin
                col_reg[0] <= '0;
                col_reg[1] <= '0;
                col_reg[2] <= '0;
            end
            COL_ONE: begin
                col_reg[0] <= CHAN_ONE;
                col_reg[1] <= CHAN_ONE;
                col_reg[2] <= CHAN_ONE;
            end
            COL_RD: begin
                col_reg[0] <= rd_color_reg[15:0];
                col_reg[1] <= rd_color_reg[31:16];
                col_reg[2] <= rd_color_reg[47:32];
            end
            default: ;
        endcase
        if (cmd.status_set) begin
            status_reg <= cmd.status_val;
        end
        if (cmd.div_start) begin
            divisor_reg <= gap;
            rem_reg     <= '0;
            quo_reg     <= '0;
            div_cnt_reg <= 5'(DIV_STEPS);
        end else if (cmd.div_step) begin
            rem_reg     <= qbit ? 16'(trial - {1'b0, divisor_reg}) : trial[15:0];
            quo_reg     <= {quo_reg[INV_W-2:0], qbit};
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_comb begin
        sts.op          = in_reg.opcode;
        sts.cnt_zero    = (cnt_reg == '0);
        sts.cnt_full    = (cnt_reg >= CW'(MAX_POINTS));
        sts.t_le        = (in_reg.time_req <= rd_time_reg);
        sts.t_ge        = (in_reg.time_req >= rd_time_reg);
        sts.gap_le_min  = (gap <= min_spacing);
        sts.idx_lt_last = ((CW'(idx_reg) + CW'(1)) < cnt_reg);
        sts.div_done    = (div_cnt_reg == 5'd1);
        sts.lerp_done   = (ch_reg == 2'd2);
    end

    always_comb begin
        result.status      = status_reg;
        result.red_out     = col_reg[0];
        result.green_out   = col_reg[1];
        result.blue_out    = col_reg[2];
        result.point_total = 7'(cnt_reg);
    end

    cnt_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table depth");
    frac_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lerp_step |-> frac_reg <= FRAC_ONE)
        else $error("fraction above one");
    div_len_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> div_cnt_reg != 5'd0)
        else $error("divider stepped past its last bit");

endmodule

[hw/rtl/cgi_controller.sv]
// Controller: sequences clear, append and query over the datapath.
module cgi_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_free,
    output logic             emit,
    input  cgi_pkg::dp_sts_t sts,
    output cgi_pkg::dp_cmd_t cmd
);
    import cgi_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_WAIT      = 4'd2;
    localparam logic [3:0] S_CHK_FIRST = 4'd3;
    localparam logic [3:0] S_CHK_LAST  = 4'd4;
    localparam logic [3:0] S_SEARCH    = 4'd5;
    localparam logic [3:0] S_INTERP    = 4'd6;
    localparam logic [3:0] S_FRAC      = 4'd7;
    localparam logic [3:0] S_LERP      = 4'd8;
    localparam logic [3:0] S_A_CHK     = 4'd9;
    localparam logic [3:0] S_DIV       = 4'd10;
    localparam logic [3:0] S_A_WR      = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        emit       = 1'b0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                cmd.status_set = 1'b1;
                cmd.status_val = ST_OK;
                cmd.col_op     = COL_ZERO;
                state_next     = S_EMIT;
                case (sts.op)
                    OP_CLEAR: cmd.cnt_clear = 1'b1;
                    OP_APPEND: begin
                        if (sts.cnt_zero) begin
                            cmd.append_wr = 1'b1;
                        end else begin
                            cmd.status_set = 1'b0;
                            cmd.idx_op     = IDX_LAST;
                            ret_next       = S_A_CHK;
                            state_next     = S_WAIT;
                        end
                    end
                    OP_QUERY: begin
                        if (sts.cnt_zero) begin
                            cmd.status_val = ST_EMPTY;
                            cmd.col_op     = COL_ONE;
                        end else begin
                            cmd.status_set = 1'b0;
                            cmd.col_op     = COL_HOLD;
                            cmd.idx_op     = IDX_ZERO;
                            ret_next       = S_CHK_FIRST;
                            state_next     = S_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_WAIT: state_next = ret_reg;
            S_CHK_FIRST: begin
                if (sts.t_le) begin
                    cmd.col_op     = COL_RD;
                    cmd.status_set = 1'b1;
                    cmd.status_val = ST_OK;
                    state_next     = S_EMIT;
                end else begin
                    cmd.idx_op = IDX_LAST;
                    ret_next   = S_CHK_LAST;
                    state_next = S_WAIT;
                end
            end
            S_CHK_LAST: begin
                if (sts.t_ge) begin
                    cmd.col_op     = COL_RD;
                    cmd.status_set = 1'b1;
                    cmd.status_val = ST_OK;
                    state_next     = S_EMIT;
                end else begin
                    cmd.idx_op = IDX_ONE;
                    ret_next   = S_SEARCH;
                    state_next = S_WAIT;
                end
            end
            S_SEARCH: begin
                if (sts.idx_lt_last && !sts.t_le) begin
                    cmd.idx_op = IDX_INC;
                    ret_next   = S_SEARCH;
                end else begin
                    cmd.cb_cap = 1'b1;
                    cmd.idx_op = IDX_DEC;
                    ret_next   = S_INTERP;
                end
                state_next = S_WAIT;
            end
            S_INTERP: begin
                cmd.mul_cap = 1'b1;
                state_next  = S_FRAC;
            end
            S_FRAC: begin
                cmd.frac_cap = 1'b1;
                state_next   = S_LERP;
            end
            S_LERP: begin
                cmd.lerp_step = 1'b1;
                if (sts.lerp_done) begin
                    cmd.status_set = 1'b1;
                    cmd.status_val = ST_OK;
                    state_next     = S_EMIT;
                end
            end
            S_A_CHK: begin
                cmd.col_op     = COL_ZERO;
                cmd.status_set = 1'b1;
                state_next     = S_EMIT;
                if (!sts.t_ge) begin
                    cmd.cnt_clear  = 1'b1;
                    cmd.status_val = ST_ORDER;
                end else if (sts.gap_le_min) begin
                    cmd.status_val = ST_DROP;
                end else if (sts.cnt_full) begin
                    cmd.status_val = ST_FULL;
                end else begin
                    cmd.status_set = 1'b0;
                    cmd.div_start  = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = S_A_WR;
                end
            end
            S_A_WR: begin
                cmd.append_wr  = 1'b1;
                cmd.status_set = 1'b1;
                cmd.status_val = ST_OK;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

[hw/rtl/color_gradient_interpolator_unit.sv]
// Top level of the colour gradient interpolator: handshakes, register port, result beat.
// Holds up to MAX_POINTS gradient keys (time Q0.16, RGB Q4.12 with 4096 = 1.0) and takes
// one beat at a time: opcode 0 clears the table, 1 appends a key, 2 queries a colour.
// Every beat gives exactly one result beat with a status and the point count after it.
// Clear, unused opcodes, empty-table cases and the first append go straight to the result
// beat; a later append reads the last key, runs a 23-step restoring divider for the
// reciprocal of the gap, then writes. A query at or before the first key or at or after
// the last is clamped to that key; inside the range it scans keys from the second one
// upward, each by a registered memory read then a compare, then runs the multiply,
// fraction, a three-step channel lerp and the result beat.
// The result sits in an output register, so the next beat is taken
// while it waits for m_ready. min_spacing sits at byte address 0 of the register port
// and should be written only while the block is idle. Key memories have no reset.
module color_gradient_interpolator_unit #(
    parameter int MAX_POINTS = cgi_pkg::DEF_MAX_POINTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cgi_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output cgi_pkg::out_item_t m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cgi_pkg::*;

    logic       min_spacing_reg;
    logic [15:0] min_sp_reg;
    logic       m_valid_reg;
    out_item_t  m_payload_reg;
    out_item_t  result;
    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic       emit;
    logic       out_free;

    // register port: one register, min_spacing, at address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, min_sp_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sp_reg      <= MIN_SPACING_RST;
            min_spacing_reg <= 1'b0;
        end else begin
            min_spacing_reg <= psel && penable && pwrite;
            if (psel && penable && pwrite && paddr[2] == 1'b0) begin
                min_sp_reg <= pwdata[15:0];
            end
        end
    end

    // result beat register decouples the two channels
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_payload_reg <= result;
        end
    end

    cgi_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .emit     (emit),
        .sts      (sts),
        .cmd      (cmd)
    );

    cgi_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_item     (s_payload),
        .min_spacing (min_sp_reg),
        .cmd         (cmd),
        .sts         (sts),
        .result      (result)
    );

    emit_slot_a: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result beat overwritten before it was taken");
    one_beat_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken while one is in work");
    empty_color_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && result.status == ST_EMPTY) |->
        (result.red_out == CHAN_ONE && result.point_total == 7'd0))
        else $error("empty-table query not reported as white");
    cfg_seen_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_spacing_reg && $past(paddr[2] == 1'b0)) |-> min_sp_reg == $past(pwdata[15:0]))
        else $error("min_spacing write lost");

endmodule
